/* hdl/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Shared constants, status codes and the per-byte result type.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  // Longest frame that the byte position counter tracks before it saturates.
  localparam int unsigned MaxFrameLen = 511;
  localparam int unsigned PosW        = $clog2(MaxFrameLen + 1);
  // Frame length is one more than the last position, so it needs one more bit.
  localparam int unsigned LenW        = PosW + 1;

  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FuncReadHolding = 8'h03;
  localparam logic [7:0] FuncWriteSingle = 8'h06;
  localparam int unsigned FuncExceptionBit = 7;

  // Byte positions of the header fields.
  localparam logic [PosW-1:0] PosAddress  = PosW'(0);
  localparam logic [PosW-1:0] PosFunction = PosW'(1);
  localparam logic [PosW-1:0] PosCount    = PosW'(2);
  localparam logic [PosW-1:0] PosData     = PosW'(3);

  // Frame length limits.
  localparam logic [LenW-1:0] MinFrameLen     = LenW'(4);
  localparam logic [LenW-1:0] MinExceptionLen = LenW'(5);
  localparam logic [LenW-1:0] ReadOverhead    = LenW'(5);
  localparam logic [LenW-1:0] WriteSingleLen  = LenW'(8);

  localparam logic [7:0] ExpectedAddressReset = 8'h01;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusShort       = 3'd1,
    StatusAddress     = 3'd2,
    StatusException   = 3'd3,
    StatusLength      = 3'd4,
    StatusUnsupported = 3'd5,
    StatusCrc         = 3'd6
  } frame_status_e;

  typedef struct packed {
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic          frame_done;
    frame_status_e frame_status;
    logic [7:0]    exception_code;
    logic [7:0]    function_seen;
  } result_t;

endpackage

/* hdl/mbrc_crc16_byte.sv */
// ----------------------------------------------------------------------------
// Byte-wide CRC-16 update
// Folds one byte into a reflected Modbus CRC-16, all eight bit steps unrolled.
// ----------------------------------------------------------------------------
module mbrc_crc16_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import mbrc_pkg::*;

  always_comb begin
    logic [15:0] acc;
    acc = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

/* hdl/mbrc_frame_check.sv */
// ----------------------------------------------------------------------------
// Frame state and checks
// Holds the per-frame state and computes the result for the current byte.
// ----------------------------------------------------------------------------
module mbrc_frame_check (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             last_byte_i,
  input  logic [7:0]       expected_address_i,
  output mbrc_pkg::result_t result_o
);
  import mbrc_pkg::*;

  logic [PosW-1:0] pos_q,  pos_d;
  logic [15:0]     crc_q,  crc_d;
  logic [7:0]      addr_q, addr_d;
  logic [7:0]      func_q, func_d;
  logic [7:0]      cnt_q,  cnt_d;

  logic [LenW-1:0] rx_len;
  logic [LenW-1:0] data_end;
  logic            in_data;

  mbrc_crc16_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (rx_byte_i),
    .crc_o  (crc_d)
  );

  assign addr_d = (pos_q == PosAddress)  ? rx_byte_i : addr_q;
  assign func_d = (pos_q == PosFunction) ? rx_byte_i : func_q;
  assign cnt_d  = (pos_q == PosCount)    ? rx_byte_i : cnt_q;

  // The position holds at its limit; the CRC keeps running.
  assign pos_d  = (pos_q != PosW'(MaxFrameLen)) ? pos_q + PosW'(1) : pos_q;

  assign rx_len    = LenW'(pos_q) + LenW'(1);
  assign data_end  = LenW'(PosData) + LenW'(cnt_d);
  assign in_data   = (pos_q >= PosData) && (LenW'(pos_q) < data_end);

  always_comb begin
    frame_status_e status;
    logic [7:0]    exc;
    status = StatusOk;
    exc    = 8'h00;
    if (last_byte_i) begin
      if (rx_len < MinFrameLen) begin
        status = StatusShort;
      end else if (addr_d != expected_address_i) begin
        status = StatusAddress;
      end else if (func_d[FuncExceptionBit]) begin
        if (rx_len < MinExceptionLen) begin
          status = StatusShort;
        end else begin
          status = StatusException;
          exc    = cnt_d;
        end
      end else if ((func_d == FuncReadHolding) &&
                   (rx_len != ReadOverhead + LenW'(cnt_d))) begin
        status = StatusLength;
      end else if ((func_d == FuncWriteSingle) && (rx_len != WriteSingleLen)) begin
        status = StatusLength;
      end else if ((func_d != FuncReadHolding) && (func_d != FuncWriteSingle)) begin
        status = StatusUnsupported;
      end else if (crc_d != 16'h0000) begin
        // A good frame leaves a zero residue once its own CRC is folded in.
        status = StatusCrc;
      end
    end
    result_o.payload_valid  = (func_d == FuncReadHolding) && in_data;
    result_o.payload_byte   = result_o.payload_valid ? rx_byte_i : 8'h00;
    result_o.frame_done     = last_byte_i;
    result_o.frame_status   = status;
    result_o.exception_code = exc;
    result_o.function_seen  = func_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CrcSeed;
      addr_q <= '0;
      func_q <= '0;
      cnt_q  <= '0;
    end else if (advance_i) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        crc_q  <= CrcSeed;
        addr_q <= '0;
        func_q <= '0;
        cnt_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        crc_q  <= crc_d;
        addr_q <= addr_d;
        func_q <= func_d;
        cnt_q  <= cnt_d;
      end
    end
  end

endmodule

/* hdl/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Checks a received Modbus RTU response byte by byte and reports its status.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  -------------------------------
//   in        sink       in_valid_i/in_stall_o   rx_byte_i, last_byte_i
//   out       source     out_valid_o/out_stall_i payload_*, frame_*, exception_
//                                                code_o, function_seen_o
//   cfg       sink       cfg_we_i                cfg_wdata_i (expected address)
//
// Each byte passes through the input register and then the result register.
// One byte is taken every cycle unless in_stall_o is high; the byte-wide CRC
// update and the status checks sit between those two registers.
// Reset clears the frame state, sets the expected address to 1 and empties
// both registers. A stall on the output holds the result register, and the
// input keeps taking bytes until the input register is also full.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic       frame_done_o,
  output logic [2:0] frame_status_o,
  output logic [7:0] exception_code_o,
  output logic [7:0] function_seen_o
);
  import mbrc_pkg::*;

  logic       exp_addr_q;
  logic [7:0] exp_addr_val_q;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic       out_valid_q;
  result_t    out_result_q;
  result_t    result;

  logic       advance;
  logic       in_xfer;

  // The byte in the input register moves on when the result register is
  // empty or its result is being taken in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Expected address register; exp_addr_q marks that reset has released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q     <= 1'b0;
      exp_addr_val_q <= ExpectedAddressReset;
    end else begin
      exp_addr_q <= 1'b1;
      if (cfg_we_i) begin
        exp_addr_val_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= rx_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  mbrc_frame_check u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance && exp_addr_q),
    .rx_byte_i          (in_byte_q),
    .last_byte_i        (in_last_q),
    .expected_address_i (exp_addr_val_q),
    .result_o           (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = out_result_q.payload_valid;
  assign payload_byte_o   = out_result_q.payload_byte;
  assign frame_done_o     = out_result_q.frame_done;
  assign frame_status_o   = out_result_q.frame_status;
  assign exception_code_o = out_result_q.exception_code;
  assign function_seen_o  = out_result_q.function_seen;

endmodule
